@@ rtl/rgbled_pkg.sv @@
// shared types and constants for the rgb led strip bit encoder
package rgbled_pkg;

    localparam int unsigned PIX_BITS   = 24;
    localparam int unsigned CH_W       = 8;
    localparam int unsigned BRIGHT_W   = 7;
    localparam int unsigned PROD_W     = CH_W + BRIGHT_W;
    localparam int unsigned SLOT_W     = 16;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [BRIGHT_W-1:0] BRIGHT_MAX = 7'd100;

    // divide by 100: multiply by 5243, shift right by 19, exact for products up to 25500
    localparam int unsigned       RECIP_W    = 13;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
    localparam int unsigned       RECIP_SH   = 19;
    localparam int unsigned       QPROD_W    = PROD_W + RECIP_W;

    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_WIDTH = 2'd2;

    localparam logic [BRIGHT_W-1:0] RST_BRIGHTNESS = 7'd100;
    localparam logic [SLOT_W-1:0]   RST_ONE_WIDTH  = 16'd29;
    localparam logic [SLOT_W-1:0]   RST_ZERO_WIDTH = 16'd14;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            last_pixel;
    } pix_in_t;

    typedef struct packed {
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] blue;
        logic            last_pixel;
    } pix_lvl_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_width;
        logic              is_reset_slot;
        logic              last_of_run;
    } slot_out_t;

    typedef struct packed {
        logic load_prod;
        logic load_level;
    } lane_ctl_t;

endpackage

@@ rtl/rgb_led_strip_bit_encoder.sv @@
// top level of the rgb led strip bit encoder
//
// input channel s_*: one pixel per transfer (red, green, blue, last_pixel).
// three dimming lanes scale the channels by brightness/100 in two pipeline
// stages, then the serializer emits the 24 bit slots on m_*, green, red,
// blue, msb first; a last pixel is followed by RESET_SLOTS zero reset slots.
// path: a pixel passes the lane product and level registers, then the
// serializer's bit and output registers, before its first slot is on m_*.
// throughput: one slot per cycle while m_ready allows, so 24 slots per pixel
// and 24 + RESET_SLOTS for a last pixel. the next pixel is taken during
// its predecessor's final slot, so runs follow without a gap.
// when m_ready is low the current slot holds and the lanes stall behind the
// serializer; s_ready drops once both lane stages are full.
// reset (aresetn low, synchronous) empties the pipeline and returns
// brightness to 100, one width to 29 and zero width to 14.
// configuration: cfg_we writes cfg_wdata to register cfg_index at once;
// index 0 brightness (bits 6:0, values above 100 act as 100), 1 one width,
// 2 zero width, other indexes ignored. write only while idle.
module rgb_led_strip_bit_encoder
    import rgbled_pkg::*;
#(
    parameter int unsigned RESET_SLOTS = 40
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pix_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output slot_out_t            m_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SLOT_W-1:0]    cfg_wdata
);

    logic [BRIGHT_W-1:0] bright_reg;
    logic [SLOT_W-1:0]   one_width_reg;
    logic [SLOT_W-1:0]   zero_width_reg;
    logic [BRIGHT_W-1:0] bright_eff;

    logic      v1_reg, v2_reg;
    logic      last1_reg, last2_reg;
    logic      adv1, adv2;
    logic      ser_ready;
    lane_ctl_t ctl;
    pix_lvl_t  lvl;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bright_reg     <= RST_BRIGHTNESS;
            one_width_reg  <= RST_ONE_WIDTH;
            zero_width_reg <= RST_ZERO_WIDTH;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_BRIGHTNESS: bright_reg     <= cfg_wdata[BRIGHT_W-1:0];
                CFG_ONE_WIDTH:  one_width_reg  <= cfg_wdata;
                CFG_ZERO_WIDTH: zero_width_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign bright_eff = (bright_reg > BRIGHT_MAX) ? BRIGHT_MAX : bright_reg;

    always_comb begin
        adv2           = !v2_reg || ser_ready;
        adv1           = !v1_reg || adv2;
        ctl.load_prod  = adv1;
        ctl.load_level = adv2;
    end

    assign s_ready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg <= s_valid;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            last1_reg <= s_data.last_pixel;
        end
        if (adv2) begin
            last2_reg <= last1_reg;
        end
    end

    rgbled_dim_lane u_lane_green (
        .aclk   (aclk),
        .ctl    (ctl),
        .value  (s_data.green),
        .bright (bright_eff),
        .level  (lvl.green)
    );

    rgbled_dim_lane u_lane_red (
        .aclk   (aclk),
        .ctl    (ctl),
        .value  (s_data.red),
        .bright (bright_eff),
        .level  (lvl.red)
    );

    rgbled_dim_lane u_lane_blue (
        .aclk   (aclk),
        .ctl    (ctl),
        .value  (s_data.blue),
        .bright (bright_eff),
        .level  (lvl.blue)
    );

    assign lvl.last_pixel = last2_reg;

    rgbled_serializer #(
        .RESET_SLOTS (RESET_SLOTS)
    ) u_serializer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (v2_reg),
        .in_ready   (ser_ready),
        .in_data    (lvl),
        .one_width  (one_width_reg),
        .zero_width (zero_width_reg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

@@ rtl/rgbled_dim_lane.sv @@
// one color channel lane: brightness product, then divide by 100 by reciprocal
module rgbled_dim_lane
    import rgbled_pkg::*;
(
    input  logic                aclk,
    input  lane_ctl_t           ctl,
    input  logic [CH_W-1:0]     value,
    input  logic [BRIGHT_W-1:0] bright,
    output logic [CH_W-1:0]     level
);

    logic [PROD_W-1:0]  product_reg;
    logic [PROD_W-1:0]  product_next;
    logic [CH_W-1:0]    level_reg;
    logic [CH_W-1:0]    level_next;
    logic [QPROD_W-1:0] qprod;

    assign product_next = PROD_W'(value) * PROD_W'(bright);
    assign qprod        = QPROD_W'(product_reg) * QPROD_W'(RECIP_100);
    assign level_next   = qprod[RECIP_SH+CH_W-1:RECIP_SH];
    assign level        = level_reg;

    always_ff @(posedge aclk) begin
        if (ctl.load_prod) begin
            product_reg <= product_next;
        end
        if (ctl.load_level) begin
            level_reg <= level_next;
        end
    end

endmodule

@@ rtl/rgbled_serializer.sv @@
// merges the lane levels into a 24 bit word and emits one slot per cycle while the output is not stalled
module rgbled_serializer
    import rgbled_pkg::*;
#(
    parameter int unsigned RESET_SLOTS = 40
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  pix_lvl_t          in_data,
    input  logic [SLOT_W-1:0] one_width,
    input  logic [SLOT_W-1:0] zero_width,
    output logic              m_valid,
    input  logic              m_ready,
    output slot_out_t         m_data
);

    localparam int unsigned TOTAL = PIX_BITS + RESET_SLOTS;
    localparam int unsigned CNT_W = $clog2(TOTAL);

    logic                busy_reg, busy_next;
    logic [PIX_BITS-1:0] bits_reg, bits_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                last_reg, last_next;
    logic                out_valid_reg, out_valid_next;
    slot_out_t           out_data_reg, out_data_next;

    logic      adv;
    logic      emit;
    logic      pixel_phase;
    logic      slot_final;
    slot_out_t slot;

    always_comb begin
        adv         = !out_valid_reg || m_ready;
        emit        = busy_reg && adv;
        pixel_phase = cnt_reg < CNT_W'(PIX_BITS);
        slot_final  = pixel_phase ? (!last_reg && cnt_reg == CNT_W'(PIX_BITS - 1))
                                  : (cnt_reg == CNT_W'(TOTAL - 1));
        in_ready    = !busy_reg || (emit && slot_final);

        slot.slot_width    = pixel_phase ? (bits_reg[PIX_BITS-1] ? one_width : zero_width)
                                         : '0;
        slot.is_reset_slot = !pixel_phase;
        slot.last_of_run   = slot_final;

        busy_next      = busy_reg;
        bits_next      = bits_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (emit) begin
            out_valid_next = 1'b1;
            out_data_next  = slot;
            cnt_next       = cnt_reg + CNT_W'(1);
            bits_next      = {bits_reg[PIX_BITS-2:0], 1'b0};
            if (slot_final) begin
                busy_next = 1'b0;
            end
        end else if (adv) begin
            out_valid_next = 1'b0;
        end

        if (in_valid && in_ready) begin
            busy_next = 1'b1;
            bits_next = {in_data.green, in_data.red, in_data.blue};
            cnt_next  = '0;
            last_next = in_data.last_pixel;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bits_reg     <= bits_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    a_pixel_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !last_reg |-> cnt_reg < CNT_W'(PIX_BITS))
        else $error("pixel slot count beyond pixel bits");

    a_reset_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg.is_reset_slot |-> out_data_reg.slot_width == '0)
        else $error("reset slot with nonzero width");

    a_load_on_final: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready && busy_reg |-> emit && slot_final)
        else $error("new pixel loaded before run finished");

    a_final_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && slot_final && !in_valid |=> !busy_reg)
        else $error("still busy after final slot");

endmodule

@@ verif/rgb_led_strip_bit_encoder_test.sv @@
// self-checking testbench for the rgb led strip bit encoder: directed and random pixels
`timescale 1ns / 100ps

module rgb_led_strip_bit_encoder_test;
    import rgbled_pkg::*;

    localparam int unsigned RESET_SLOTS  = 40;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    pix_in_t              s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    slot_out_t            m_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_BRIGHTNESS;
    logic [SLOT_W-1:0]    cfg_wdata = '0;

    logic [BRIGHT_W-1:0] cur_brightness = RST_BRIGHTNESS;
    logic [SLOT_W-1:0]   cur_one_width  = RST_ONE_WIDTH;
    logic [SLOT_W-1:0]   cur_zero_width = RST_ZERO_WIDTH;

    slot_out_t   slot_queue[$];
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned errors = 0;
    int unsigned cycle_count = 0;
    int unsigned pixels_sent = 0;
    int unsigned strip_ends = 0;
    int unsigned slots_checked = 0;
    int unsigned settings_used = 0;

    rgb_led_strip_bit_encoder #(
        .RESET_SLOTS(RESET_SLOTS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [CH_W-1:0] dim_level(input logic [CH_W-1:0] level);
        int unsigned pct;
        pct = (cur_brightness > BRIGHT_MAX) ? BRIGHT_MAX : cur_brightness;
        return CH_W'((level * pct) / 100);
    endfunction

    // green, red, blue, msb first, then the latch pulse on a strip end
    function automatic void encode_pixel(input pix_in_t pix);
        logic [PIX_BITS-1:0] bits;
        slot_out_t           slot;
        bits = {dim_level(pix.green), dim_level(pix.red), dim_level(pix.blue)};
        for (int i = PIX_BITS - 1; i >= 0; i--) begin
            slot.slot_width    = bits[i] ? cur_one_width : cur_zero_width;
            slot.is_reset_slot = 1'b0;
            slot.last_of_run   = !pix.last_pixel && (i == 0);
            slot_queue.push_back(slot);
        end
        if (pix.last_pixel) begin
            for (int k = 0; k < RESET_SLOTS; k++) begin
                slot.slot_width    = '0;
                slot.is_reset_slot = 1'b1;
                slot.last_of_run   = (k == RESET_SLOTS - 1);
                slot_queue.push_back(slot);
            end
        end
    endfunction

    always @(posedge aclk) begin
        slot_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (slot_queue.size() == 0) begin
                errors++;
                $display("%0t: unexpected slot, expected none, got width %0d reset %0b last %0b",
                         $time, m_data.slot_width, m_data.is_reset_slot, m_data.last_of_run);
            end else begin
                want = slot_queue.pop_front();
                slots_checked++;
                if (m_data.slot_width !== want.slot_width
                        || m_data.is_reset_slot !== want.is_reset_slot
                        || m_data.last_of_run !== want.last_of_run) begin
                    errors++;
                    $display("%0t: slot mismatch, expected width %0d reset %0b last %0b, got width %0d reset %0b last %0b",
                             $time, want.slot_width, want.is_reset_slot, want.last_of_run,
                             m_data.slot_width, m_data.is_reset_slot, m_data.last_of_run);
                end
            end
        end
    end

    task automatic send_pixel(input logic [CH_W-1:0] red, input logic [CH_W-1:0] green,
                              input logic [CH_W-1:0] blue, input logic last_pixel);
        pix_in_t pix;
        pix.red        = red;
        pix.green      = green;
        pix.blue       = blue;
        pix.last_pixel = last_pixel;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= pix;
        do @(posedge aclk); while (!s_ready);
        encode_pixel(pix);
        pixels_sent++;
        if (last_pixel) strip_ends++;
    endtask

    task automatic wait_until_drained;
        s_valid <= 1'b0;
        while (slot_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [SLOT_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (index)
            CFG_BRIGHTNESS: cur_brightness = data[BRIGHT_W-1:0];
            CFG_ONE_WIDTH:  cur_one_width  = data;
            CFG_ZERO_WIDTH: cur_zero_width = data;
            default: ;
        endcase
        settings_used++;
        @(posedge aclk);
    endtask

    task automatic send_random_pixel;
        send_pixel(CH_W'($urandom_range(255)), CH_W'($urandom_range(255)),
                   CH_W'($urandom_range(255)), $urandom_range(4) == 0);
    endtask

    task automatic test_reset_defaults;
        send_pixel(8'hFF, 8'h00, 8'hA5, 1'b0);
        send_pixel(8'h3C, 8'hC3, 8'h01, 1'b1);
        send_pixel(8'h55, 8'hAA, 8'h80, 1'b0);
        wait_until_drained();
    endtask

    task automatic test_field_extremes;
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
        send_pixel(8'h80, 8'h01, 8'h7F, 1'b0);
        wait_until_drained();
    endtask

    // includes values above 100 and stray upper data bits
    task automatic test_brightness;
        logic [SLOT_W-1:0] levels[8];
        levels = '{16'd0, 16'd1, 16'd50, 16'd99, 16'd100, 16'd101, 16'd127, 16'hFF85};
        foreach (levels[i]) begin
            write_reg(CFG_BRIGHTNESS, levels[i]);
            send_pixel(8'hFF, 8'hC8, 8'h63, i == 7);
            wait_until_drained();
        end
        write_reg(CFG_BRIGHTNESS, 16'd100);
    endtask

    task automatic test_pulse_widths;
        write_reg(CFG_ONE_WIDTH, 16'd0);
        write_reg(CFG_ZERO_WIDTH, 16'hFFFF);
        send_pixel(8'hF0, 8'h0F, 8'h99, 1'b1);
        wait_until_drained();
        write_reg(CFG_ONE_WIDTH, 16'hFFFF);
        write_reg(CFG_ZERO_WIDTH, 16'd0);
        send_pixel(8'h0F, 8'hF0, 8'h66, 1'b0);
        wait_until_drained();
        write_reg(CFG_ONE_WIDTH, 16'd7);
        write_reg(CFG_ZERO_WIDTH, 16'd7);
        send_pixel(8'h12, 8'h34, 8'h56, 1'b0);
        wait_until_drained();
    endtask

    // writes to the unused index must leave every register alone
    task automatic test_unused_index;
        write_reg(CFG_ONE_WIDTH, 16'd29);
        write_reg(CFG_ZERO_WIDTH, 16'd14);
        write_reg(CFG_UNUSED, 16'hFFFF);
        write_reg(CFG_UNUSED, 16'h0000);
        send_pixel(8'hA5, 8'h5A, 8'hC3, 1'b1);
        wait_until_drained();
    endtask

    task automatic randomize_config;
        if ($urandom_range(3) == 0) write_reg(CFG_BRIGHTNESS, SLOT_W'($urandom_range(16'hFFFF)));
        else write_reg(CFG_BRIGHTNESS, SLOT_W'($urandom_range(100)));
        write_reg(CFG_ONE_WIDTH, SLOT_W'($urandom_range(16'hFFFF)));
        write_reg(CFG_ZERO_WIDTH, SLOT_W'($urandom_range(16'hFFFF)));
    endtask

    task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                       input int unsigned n_items);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int unsigned i = 0; i < n_items; i++) begin
            if (i % 25 == 0) begin
                wait_until_drained();
                randomize_config();
            end else if (i % 25 == 12) begin
                wait_until_drained();
            end
            send_random_pixel();
        end
        wait_until_drained();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 23;
        recv_idle_pct = 66;
        test_reset_defaults();
        test_field_extremes();
        test_brightness();
        test_pulse_widths();
        test_unused_index();

        test_random_traffic(23, 66, 75);
        test_random_traffic(66, 23, 75);
        test_random_traffic(0, 0, 70);

        wait_until_drained();
        $display("Sent %0d pixels (%0d strip ends) over %0d register writes",
                 pixels_sent, strip_ends, settings_used);
        $display("Checked %0d slots with %0d mismatches", slots_checked, errors);
        if (errors == 0 && slot_queue.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
